@@ src/tdq_pkg.sv @@
package tdq_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned REF_W   = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned TOTAL_W = 20;
  // length, reference and stamp of one stored descriptor
  localparam int unsigned ENT_DATA_W = LEN_W + REF_W + STAMP_W;

  localparam logic [COUNT_W-1:0] MAX_RESULTS    = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 5'd31;
  localparam logic [LEN_W-1:0]   NOT_FOUND_LEN  = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_COUNT = 3'd3,
    ACT_SEEK  = 3'd4,
    ACT_CLEAR = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               found;
    logic [KEY_W-1:0]   tag;
    logic [LEN_W-1:0]   length;
    logic [REF_W-1:0]   ref_addr;
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic               full;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               hit;
    logic               in_range;
    logic               past_end;
    logic [TOTAL_W-1:0] total_nxt;
  } eval_t;

endpackage

@@ src/tdq_store.sv @@
module tdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 128,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while the sequencer stalls
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/tdq_match.sv @@
module tdq_match #(
  parameter int unsigned TW = 16,
  parameter int unsigned IW = 5
) (
  input  logic [TW-1:0]               ent_tag_i,
  input  logic [tdq_pkg::LEN_W-1:0]   ent_len_i,
  input  logic [TW-1:0]               key_tag_i,
  input  logic                        any_i,
  input  logic [IW-1:0]               idx_i,
  input  logic [IW-1:0]               from_i,
  input  logic [IW-1:0]               to_i,
  input  logic [tdq_pkg::TOTAL_W-1:0] total_i,
  output tdq_pkg::eval_t              eval_o
);
  import tdq_pkg::*;

  always_comb begin
    eval_o.hit       = any_i || (ent_tag_i == key_tag_i);
    eval_o.in_range  = (idx_i >= from_i);
    eval_o.past_end  = (idx_i >= to_i);
    eval_o.total_nxt = total_i + TOTAL_W'(ent_len_i);
  end

endmodule

@@ src/tdq_ctrl.sv @@
module tdq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned TW = (TAG_BITS < 16) ? TAG_BITS : 16,
  localparam int unsigned EW = TW + tdq_pkg::ENT_DATA_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tdq_pkg::action_e            action_i,
  input  logic [tdq_pkg::KEY_W-1:0]   tag_i,
  input  logic                        any_i,
  input  logic [tdq_pkg::LEN_W-1:0]   len_i,
  input  logic [tdq_pkg::REF_W-1:0]   ref_i,
  input  logic [tdq_pkg::STAMP_W-1:0] stamp_i,
  input  logic [tdq_pkg::IDX_W-1:0]   from_i,
  input  logic [tdq_pkg::IDX_W-1:0]   to_i,
  input  logic                        slot_free_i,
  output logic                        emit_o,
  output tdq_pkg::res_t               res_o,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [EW-1:0]               wr_data_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic [EW-1:0]               rd_data_i
);
  import tdq_pkg::*;

  localparam int unsigned IW = (OW > IDX_W) ? OW : IDX_W;

  state_e               state_q, state_d;
  action_e              act_q, act_d;
  logic [TW-1:0]        tag_q, tag_d;
  logic                 any_q, any_d;
  logic [IW-1:0]        from_q, from_d;
  logic [IW-1:0]        to_q, to_d;
  logic [OW-1:0]        occ_q, occ_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [AW-1:0]        shift_q, shift_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  logic [COUNT_W-1:0]   k_q, k_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  res_t                 pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;
  res_t                 fin_q, fin_d;

  logic [OW-1:0]        nxt;
  logic [OW-1:0]        nxt2;
  logic                 last_ent;
  res_t                 ent_res;
  eval_t                ev;

  // stored entry layout from the bottom: tag, length, reference, stamp
  tdq_match #(
    .TW (TW),
    .IW (IW)
  ) u_match (
    .ent_tag_i (rd_data_i[TW-1:0]),
    .ent_len_i (rd_data_i[TW +: LEN_W]),
    .key_tag_i (tag_q),
    .any_i     (any_q),
    .idx_i     (idx_q),
    .from_i    (from_q),
    .to_i      (to_q),
    .total_i   (total_q),
    .eval_o    (ev)
  );

  assign nxt      = OW'(cur_q) + OW'(1);
  assign nxt2     = OW'(shift_q) + OW'(2);
  assign last_ent = (nxt >= occ_q);

  always_comb begin
    ent_res          = '0;
    ent_res.found    = 1'b1;
    ent_res.tag      = KEY_W'(rd_data_i[TW-1:0]);
    ent_res.length   = rd_data_i[TW +: LEN_W];
    ent_res.ref_addr = rd_data_i[TW + LEN_W +: REF_W];
    ent_res.stamp    = rd_data_i[TW + LEN_W + REF_W +: STAMP_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occ_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    tag_q   <= tag_d;
    any_q   <= any_d;
    from_q  <= from_d;
    to_q    <= to_d;
    cur_q   <= cur_d;
    shift_q <= shift_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    total_q <= total_d;
    pend_q  <= pend_d;
    fin_q   <= fin_d;
  end

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    tag_d      = tag_q;
    any_d      = any_q;
    from_d     = from_q;
    to_d       = to_q;
    occ_d      = occ_q;
    cur_d      = cur_q;
    shift_d    = shift_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    total_d    = total_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    fin_d      = fin_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    res_o      = fin_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = occ_q[AW-1:0];
    wr_data_o  = {stamp_i, ref_i, len_i, tag_i[TW-1:0]};
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d      = action_i;
          tag_d      = tag_i[TW-1:0];
          any_d      = any_i;
          from_d     = IW'(from_i);
          to_d       = IW'(to_i);
          cur_d      = '0;
          idx_d      = '0;
          cnt_d      = '0;
          k_d        = '0;
          total_d    = '0;
          pend_vld_d = 1'b0;
          fin_d      = '0;
          fin_d.last = 1'b1;
          state_d    = ST_DONE;
          unique case (action_i)
            ACT_PUSH: begin
              if (occ_q == OW'(QUEUE_DEPTH)) begin
                fin_d.full = 1'b1;
              end else begin
                wr_en_o = 1'b1;
                occ_d   = occ_q + OW'(1);
              end
            end
            ACT_POP, ACT_PEEK, ACT_COUNT, ACT_SEEK: begin
              if (occ_q != '0) begin
                rd_en_o = 1'b1;
                state_d = ST_SCAN;
              end else if (action_i == ACT_SEEK) begin
                state_d = ST_FLUSH;
              end else if (action_i != ACT_COUNT) begin
                fin_d.length = NOT_FOUND_LEN;
              end
            end
            ACT_CLEAR: begin
              occ_d = '0;
            end
            default: begin
              // unused codes: plain final word, no state change
            end
          endcase
        end
      end

      ST_SCAN: begin
        unique case (act_q)
          ACT_POP, ACT_PEEK: begin
            if (ev.hit) begin
              res_o = ent_res;
              res_o.last = 1'b1;
              if (slot_free_i) begin
                emit_o = 1'b1;
                if (act_q == ACT_PEEK) begin
                  state_d = ST_IDLE;
                end else if (last_ent) begin
                  occ_d   = occ_q - OW'(1);
                  state_d = ST_IDLE;
                end else begin
                  // close the gap: entries above move down one place
                  rd_en_o   = 1'b1;
                  rd_addr_o = nxt[AW-1:0];
                  shift_d   = cur_q;
                  state_d   = ST_SHIFT;
                end
              end
            end else if (last_ent) begin
              fin_d        = '0;
              fin_d.length = NOT_FOUND_LEN;
              fin_d.last   = 1'b1;
              state_d      = ST_DONE;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = nxt[AW-1:0];
              cur_d     = nxt[AW-1:0];
            end
          end
          ACT_COUNT: begin
            cnt_d = cnt_q + IW'(ev.hit);
            if (last_ent) begin
              fin_d       = '0;
              fin_d.count = (cnt_d > IW'(COUNT_SAT)) ? COUNT_SAT : cnt_d[COUNT_W-1:0];
              fin_d.last  = 1'b1;
              state_d     = ST_DONE;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = nxt[AW-1:0];
              cur_d     = nxt[AW-1:0];
            end
          end
          default: begin
            // seek: the newest hit waits in pend_q so that the final one
            // can carry the last flag
            if (k_q == MAX_RESULTS || (ev.hit && ev.past_end)) begin
              state_d = ST_FLUSH;
            end else if (!(ev.hit && ev.in_range && pend_vld_q && !slot_free_i)) begin
              if (ev.hit && ev.in_range) begin
                res_o      = pend_q;
                emit_o     = pend_vld_q;
                pend_d     = ent_res;
                pend_d.total = ev.total_nxt;
                pend_vld_d = 1'b1;
                total_d    = ev.total_nxt;
                k_d        = k_q + COUNT_W'(1);
              end
              if (ev.hit) begin
                idx_d = idx_q + IW'(1);
              end
              if (last_ent) begin
                state_d = ST_FLUSH;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = nxt[AW-1:0];
                cur_d     = nxt[AW-1:0];
              end
            end
          end
        endcase
      end

      ST_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = shift_q;
        wr_data_o = rd_data_i;
        if (nxt2 < occ_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = nxt2[AW-1:0];
          shift_d   = shift_q + AW'(1);
        end else begin
          occ_d   = occ_q - OW'(1);
          state_d = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (pend_vld_q) begin
          res_o = pend_q;
        end else begin
          res_o = '0;
        end
        res_o.last = 1'b1;
        if (slot_free_i) begin
          emit_o     = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      ST_DONE: begin
        res_o = fin_q;
        if (slot_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/tagged_descriptor_queue.sv @@
// channel   dir  tdata (low bit up)                                  tuser    tlast
// s_axis    in   tag16 match_any1 length16 ref32 stamp64 from5 to5    action3  -
// m_axis    out  found1 tag16 length16 ref32 stamp64 count5 total20   -        last
//                full_res1
//
// Push and clear: the word is taken, then the result is loaded into the output register.
// Pop, peek, count, seek: one read per entry scanned, then the final word is loaded
// unless a pop or peek hit sends it straight from the scan; the scan reads one descriptor
// a cycle, unless the output stalls it, through the single read port of the entry memory.
// Pop then moves each younger entry down one place to close the gap.
// Reset clears occupancy, the state and the output valid flag; the entry memory is not cleared.
// A result waits in the output register; the scan holds while it cannot hand on a word.
module tagged_descriptor_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // tag, match_any, length, ref, stamp, from, to
  input  logic [2:0]   s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,  // found, tag, length, ref, stamp, count, total, full
  output logic         m_axis_tlast
);
  import tdq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned TW = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int unsigned EW = TW + ENT_DATA_W;

  logic          slot_free;
  logic          emit;
  res_t          res;
  res_t          out_q;
  logic          out_vld_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  assign slot_free = !out_vld_q || m_axis_tready;

  tdq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (action_e'(s_axis_tuser)),
    .tag_i       (s_axis_tdata[15:0]),
    .any_i       (s_axis_tdata[16]),
    .len_i       (s_axis_tdata[32:17]),
    .ref_i       (s_axis_tdata[64:33]),
    .stamp_i     (s_axis_tdata[128:65]),
    .from_i      (s_axis_tdata[133:129]),
    .to_i        (s_axis_tdata[138:134]),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  tdq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'd0, out_q.full, out_q.total, out_q.count, out_q.stamp,
                          out_q.ref_addr, out_q.length, out_q.tag, out_q.found};

endmodule

@@ src/tdq_checker.sv @@
module tdq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  localparam int unsigned FOUND_BIT = 0;
  localparam int unsigned FULL_BIT  = 154;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

  // a rejected push carries no entry and ends its run
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FULL_BIT] |->
      !m_axis_tdata[FOUND_BIT] && m_axis_tlast)
    else $error("full result with entry or without last");

  // only seek hits come before the final word of a run
  a_mid_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[FOUND_BIT])
    else $error("non-final result without entry");

endmodule

bind tagged_descriptor_queue tdq_checker u_tdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
